// File: hw/rtl/momentum_random_walk_step_defines.svh
// ----------------------------------------------------------------------------
// Momentum random walk step - assertion macros
// Shared concurrent assertion shorthands for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef MOMENTUM_RANDOM_WALK_STEP_DEFINES_SVH
`define MOMENTUM_RANDOM_WALK_STEP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MRW_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("momentum_random_walk_step: assertion failed");

// next-cycle implication, disabled during reset
`define MRW_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("momentum_random_walk_step: assertion failed");

`endif

// File: hw/rtl/mrw_pkg.sv
// ----------------------------------------------------------------------------
// Momentum random walk step - package
// Fixed widths, register indexes, item kinds, direction codes, weight offsets and weight values.
// ----------------------------------------------------------------------------
package mrw_pkg;

   localparam int CFG_BITS  = 16;
   localparam int RND_BITS  = 31;
   localparam int OUT_BITS  = 16;
   localparam int DIR_COUNT = 8;
   localparam int DIR_BITS  = 3;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_GRID_COLS = 2'd0,
      CSR_GRID_ROWS = 2'd1,
      CSR_START_COL = 2'd2,
      CSR_START_ROW = 2'd3
   } csr_index_type;

   // item kinds
   localparam logic KIND_RESTART = 1'b0;
   localparam logic KIND_MOVE    = 1'b1;

   // directions, clockwise from up-left
   localparam logic [DIR_BITS-1:0] DIR_UP_LEFT    = 3'd0;
   localparam logic [DIR_BITS-1:0] DIR_UP         = 3'd1;
   localparam logic [DIR_BITS-1:0] DIR_UP_RIGHT   = 3'd2;
   localparam logic [DIR_BITS-1:0] DIR_RIGHT      = 3'd3;
   localparam logic [DIR_BITS-1:0] DIR_DOWN_RIGHT = 3'd4;
   localparam logic [DIR_BITS-1:0] DIR_DOWN       = 3'd5;
   localparam logic [DIR_BITS-1:0] DIR_DOWN_LEFT  = 3'd6;
   localparam logic [DIR_BITS-1:0] DIR_LEFT       = 3'd7;

   // offsets of a weight from the chosen direction
   localparam logic [DIR_BITS-1:0] OFF_AHEAD  = 3'd0;
   localparam logic [DIR_BITS-1:0] OFF_CW     = 3'd1;
   localparam logic [DIR_BITS-1:0] OFF_BACK_L = 3'd3;
   localparam logic [DIR_BITS-1:0] OFF_BACK   = 3'd4;
   localparam logic [DIR_BITS-1:0] OFF_BACK_R = 3'd5;
   localparam logic [DIR_BITS-1:0] OFF_CCW    = 3'd7;

   // weight values
   localparam int WEIGHT_INIT = 3;
   localparam int STEP_MAIN   = 3;
   localparam int STEP_SIDE   = 1;

endpackage

// File: hw/rtl/momentum_random_walk_step.sv
// ----------------------------------------------------------------------------
// Momentum random walk step - top level
// Grid walker with eight momentum weights and a serial direction picker.
// ----------------------------------------------------------------------------
// A restart beat loads the start position and resets the weights and heading;
// a move beat masks the weights and starts the remainder unit at the accepting
// edge, then takes the bit-serial remainder of random_value by the weight
// total, picks the direction, and steps and updates the weights. Either kind
// then loads the result register. A stalled earlier result delays the load.
// The block takes one item at a time and takes the next beat the cycle after
// the result is loaded. A finished result waits in the output register while
// the next item is accepted. Configuration must be written only while no item
// is in flight; the block itself does not enforce it.
module momentum_random_walk_step #(
   parameter int COORD_BITS  = 16,
   parameter int WEIGHT_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_wr_en,
   input  logic [1:0]                   csr_index,
   input  logic [mrw_pkg::CFG_BITS-1:0] csr_wdata,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic [mrw_pkg::RND_BITS-1:0] req_random_value,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mrw_pkg::OUT_BITS-1:0] rsp_pos_col,
   output logic [mrw_pkg::OUT_BITS-1:0] rsp_pos_row,
   output logic [mrw_pkg::DIR_BITS-1:0] rsp_heading
);

   localparam int TOTAL_BITS = WEIGHT_BITS + 3;
   localparam int CMP_BITS   = (COORD_BITS > mrw_pkg::CFG_BITS) ? COORD_BITS
                                                                : mrw_pkg::CFG_BITS;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_UPD,
      ST_OUT
   } state_type;

   state_type                    state_ff;
   logic [mrw_pkg::CFG_BITS-1:0] grid_cols_ff;
   logic [mrw_pkg::CFG_BITS-1:0] grid_rows_ff;
   logic [mrw_pkg::CFG_BITS-1:0] start_col_ff;
   logic [mrw_pkg::CFG_BITS-1:0] start_row_ff;
   logic [COORD_BITS-1:0]        pos_col_ff;
   logic [COORD_BITS-1:0]        pos_row_ff;
   logic [COORD_BITS-1:0]        pos_col_in;
   logic [COORD_BITS-1:0]        pos_row_in;
   logic [WEIGHT_BITS-1:0]       wgt_ff [mrw_pkg::DIR_COUNT];
   logic [WEIGHT_BITS-1:0]       wgt_mask_in [mrw_pkg::DIR_COUNT];
   logic [WEIGHT_BITS-1:0]       wgt_upd_in [mrw_pkg::DIR_COUNT];
   logic [mrw_pkg::DIR_BITS-1:0] dir_ff;
   logic [mrw_pkg::DIR_BITS-1:0] dir_in;
   logic [TOTAL_BITS-1:0]        total_in;
   logic [TOTAL_BITS-1:0]        mod_rem;
   logic                         mod_done;
   logic                         mod_start;
   logic                         req_beat;
   logic                         out_free;
   logic                         col_low;
   logic                         col_high;
   logic                         row_low;
   logic                         row_high;
   logic                         rsp_valid_ff;
   logic [mrw_pkg::OUT_BITS-1:0] rsp_pos_col_ff;
   logic [mrw_pkg::OUT_BITS-1:0] rsp_pos_row_ff;
   logic [mrw_pkg::DIR_BITS-1:0] rsp_heading_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign mod_start = req_beat && (req_kind == mrw_pkg::KIND_MOVE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= mrw_pkg::CFG_BITS'(255);
         grid_rows_ff <= mrw_pkg::CFG_BITS'(255);
         start_col_ff <= '0;
         start_row_ff <= '0;
      end else if (csr_wr_en) begin
         case (mrw_pkg::csr_index_type'(csr_index))
            mrw_pkg::CSR_GRID_COLS: grid_cols_ff <= csr_wdata;
            mrw_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr_wdata;
            mrw_pkg::CSR_START_COL: start_col_ff <= csr_wdata;
            mrw_pkg::CSR_START_ROW: start_row_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // edge detection; the low edge wins over the high edge
   always_comb begin
      col_low  = (pos_col_ff == '0);
      row_low  = (pos_row_ff == '0);
      col_high = !col_low && (CMP_BITS'(pos_col_ff) == CMP_BITS'(grid_cols_ff));
      row_high = !row_low && (CMP_BITS'(pos_row_ff) == CMP_BITS'(grid_rows_ff));
   end

   // raise zero weights, mask off-grid directions, form the total
   always_comb begin
      total_in = '0;
      for (int i = 0; i < mrw_pkg::DIR_COUNT; i++) begin
         wgt_mask_in[i] = (wgt_ff[i] == '0) ? WEIGHT_BITS'(1) : wgt_ff[i];
      end
      if (col_low) begin
         wgt_mask_in[mrw_pkg::DIR_UP_LEFT]    = '0;
         wgt_mask_in[mrw_pkg::DIR_DOWN_LEFT]  = '0;
         wgt_mask_in[mrw_pkg::DIR_LEFT]       = '0;
      end else if (col_high) begin
         wgt_mask_in[mrw_pkg::DIR_UP_RIGHT]   = '0;
         wgt_mask_in[mrw_pkg::DIR_RIGHT]      = '0;
         wgt_mask_in[mrw_pkg::DIR_DOWN_RIGHT] = '0;
      end
      if (row_low) begin
         wgt_mask_in[mrw_pkg::DIR_UP_LEFT]    = '0;
         wgt_mask_in[mrw_pkg::DIR_UP]         = '0;
         wgt_mask_in[mrw_pkg::DIR_UP_RIGHT]   = '0;
      end else if (row_high) begin
         wgt_mask_in[mrw_pkg::DIR_DOWN_RIGHT] = '0;
         wgt_mask_in[mrw_pkg::DIR_DOWN]       = '0;
         wgt_mask_in[mrw_pkg::DIR_DOWN_LEFT]  = '0;
      end
      for (int i = 0; i < mrw_pkg::DIR_COUNT; i++) begin
         total_in = total_in + TOTAL_BITS'(wgt_mask_in[i]);
      end
   end

   // remainder of the random value by the weight total
   mrw_mod_unit #(
      .DIV_BITS (TOTAL_BITS)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_random_value),
      .divisor   (total_in),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // first prefix sum above the remainder picks the direction
   always_comb begin
      logic [TOTAL_BITS-1:0] acc;
      logic                  found;
      acc    = '0;
      found  = 1'b0;
      dir_in = mrw_pkg::DIR_LEFT;
      for (int i = 0; i < mrw_pkg::DIR_COUNT; i++) begin
         acc = acc + TOTAL_BITS'(wgt_ff[i]);
         if (!found && (mod_rem < acc)) begin
            dir_in = mrw_pkg::DIR_BITS'(i);
            found  = 1'b1;
         end
      end
   end

   // step one cell in the chosen direction
   always_comb begin
      pos_col_in = pos_col_ff;
      pos_row_in = pos_row_ff;
      if (dir_ff <= mrw_pkg::DIR_UP_RIGHT) begin
         pos_row_in = pos_row_ff - 1'b1;
      end
      if ((dir_ff >= mrw_pkg::DIR_UP_RIGHT) && (dir_ff <= mrw_pkg::DIR_DOWN_RIGHT)) begin
         pos_col_in = pos_col_ff + 1'b1;
      end
      if ((dir_ff >= mrw_pkg::DIR_DOWN_RIGHT) && (dir_ff <= mrw_pkg::DIR_DOWN_LEFT)) begin
         pos_row_in = pos_row_ff + 1'b1;
      end
      if ((dir_ff >= mrw_pkg::DIR_DOWN_LEFT) || (dir_ff == mrw_pkg::DIR_UP_LEFT)) begin
         pos_col_in = pos_col_ff - 1'b1;
      end
   end

   // reinforce ahead, weaken behind, saturating both ways
   always_comb begin
      logic [mrw_pkg::DIR_BITS-1:0] off;
      logic [WEIGHT_BITS:0]         sum;
      logic [WEIGHT_BITS-1:0]       step;
      for (int j = 0; j < mrw_pkg::DIR_COUNT; j++) begin
         off  = mrw_pkg::DIR_BITS'(j) - dir_ff;
         sum  = '0;
         step = '0;
         wgt_upd_in[j] = wgt_ff[j];
         case (off)
            mrw_pkg::OFF_AHEAD: begin
               sum = {1'b0, wgt_ff[j]} + (WEIGHT_BITS + 1)'(mrw_pkg::STEP_MAIN);
               wgt_upd_in[j] = sum[WEIGHT_BITS] ? WEIGHT_MAX : sum[WEIGHT_BITS-1:0];
            end
            mrw_pkg::OFF_CW, mrw_pkg::OFF_CCW: begin
               sum = {1'b0, wgt_ff[j]} + (WEIGHT_BITS + 1)'(mrw_pkg::STEP_SIDE);
               wgt_upd_in[j] = sum[WEIGHT_BITS] ? WEIGHT_MAX : sum[WEIGHT_BITS-1:0];
            end
            mrw_pkg::OFF_BACK: begin
               step = WEIGHT_BITS'(mrw_pkg::STEP_MAIN);
               wgt_upd_in[j] = (wgt_ff[j] > step) ? (wgt_ff[j] - step) : '0;
            end
            mrw_pkg::OFF_BACK_L, mrw_pkg::OFF_BACK_R: begin
               step = WEIGHT_BITS'(mrw_pkg::STEP_SIDE);
               wgt_upd_in[j] = (wgt_ff[j] > step) ? (wgt_ff[j] - step) : '0;
            end
            default: ;
         endcase
      end
   end

   // sequencer, walker state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pos_col_ff   <= '0;
         pos_row_ff   <= '0;
         dir_ff       <= mrw_pkg::DIR_UP_LEFT;
         for (int i = 0; i < mrw_pkg::DIR_COUNT; i++) begin
            wgt_ff[i] <= WEIGHT_BITS'(mrw_pkg::WEIGHT_INIT);
         end
      end else begin
         // a taken result clears unless a new one loads in the same cycle
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  if (req_kind == mrw_pkg::KIND_RESTART) begin
                     pos_col_ff <= COORD_BITS'(start_col_ff);
                     pos_row_ff <= COORD_BITS'(start_row_ff);
                     dir_ff     <= mrw_pkg::DIR_UP_LEFT;
                     for (int i = 0; i < mrw_pkg::DIR_COUNT; i++) begin
                        wgt_ff[i] <= WEIGHT_BITS'(mrw_pkg::WEIGHT_INIT);
                     end
                     state_ff <= ST_OUT;
                  end else begin
                     wgt_ff   <= wgt_mask_in;
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (mod_done) begin
                  dir_ff   <= dir_in;
                  state_ff <= ST_UPD;
               end
            end
            ST_UPD: begin
               pos_col_ff <= pos_col_in;
               pos_row_ff <= pos_row_in;
               wgt_ff     <= wgt_upd_in;
               state_ff   <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_pos_col_ff <= mrw_pkg::OUT_BITS'(pos_col_ff);
                  rsp_pos_row_ff <= mrw_pkg::OUT_BITS'(pos_row_ff);
                  rsp_heading_ff <= dir_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_col = rsp_pos_col_ff;
   assign rsp_pos_row = rsp_pos_row_ff;
   assign rsp_heading = rsp_heading_ff;

endmodule

// File: hw/rtl/mrw_mod_unit.sv
// ----------------------------------------------------------------------------
// Momentum random walk step - remainder unit
// Restoring division, one quotient bit per cycle, remainder kept.
// ----------------------------------------------------------------------------
module mrw_mod_unit #(
   parameter int DIV_BITS = 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mrw_pkg::RND_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0]          divisor,
   output logic                         done,
   output logic [DIV_BITS-1:0]          remainder
);

   localparam int CNT_BITS = $clog2(mrw_pkg::RND_BITS);

   logic                         busy_ff;
   logic                         done_ff;
   logic [CNT_BITS-1:0]          cnt_ff;
   logic [DIV_BITS-1:0]          rem_ff;
   logic [DIV_BITS-1:0]          rem_in;
   logic [DIV_BITS-1:0]          div_ff;
   logic [mrw_pkg::RND_BITS-1:0] num_ff;
   logic [DIV_BITS:0]            trial;
   logic [DIV_BITS:0]            diff;

   // one trial subtract per cycle
   always_comb begin
      trial  = {rem_ff, num_ff[mrw_pkg::RND_BITS-1]};
      diff   = trial - {1'b0, div_ff};
      rem_in = (trial >= {1'b0, div_ff}) ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(mrw_pkg::RND_BITS - 1);
            rem_ff  <= '0;
            num_ff  <= dividend;
            div_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            num_ff <= {num_ff[mrw_pkg::RND_BITS-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: hw/rtl/mrw_checker.sv
// ----------------------------------------------------------------------------
// Momentum random walk step - port checker
// Watches the top-level channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "momentum_random_walk_step_defines.svh"

module mrw_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         req_kind,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [mrw_pkg::OUT_BITS-1:0] rsp_pos_col,
   input logic [mrw_pkg::OUT_BITS-1:0] rsp_pos_row,
   input logic [mrw_pkg::DIR_BITS-1:0] rsp_heading
);

   logic req_beat;
   logic rsp_held;
   logic restart_beat_ff;

   assign req_beat = req_valid && !req_stall;
   assign rsp_held = rsp_valid && rsp_stall;

   // a restart beat accepted in the previous cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         restart_beat_ff <= 1'b0;
      end else begin
         restart_beat_ff <= req_beat && (req_kind == mrw_pkg::KIND_RESTART);
      end
   end

   // a stalled result beat holds
   `MRW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held,
      rsp_valid && $stable(rsp_pos_col) && $stable(rsp_pos_row) && $stable(rsp_heading))

   // the block is busy right after it takes a beat
   `MRW_ASSERT_NEXT(a_busy_after_req, clock, reset, req_beat, req_stall)

   // a restart shows heading zero as soon as the output is free
   `MRW_ASSERT_NEXT(a_restart_heading, clock, reset, restart_beat_ff && !rsp_held,
      rsp_valid && (rsp_heading == mrw_pkg::DIR_UP_LEFT))

endmodule

bind momentum_random_walk_step mrw_checker u_mrw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_kind    (req_kind),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_pos_col (rsp_pos_col),
   .rsp_pos_row (rsp_pos_row),
   .rsp_heading (rsp_heading)
);

// File: bench/momentum_random_walk_step_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Momentum random walk step - testbench
// Drives restart and move beats with random gaps and response stalls, keeps
// its own model of the walker (position, eight weights, grid registers) and
// checks every response beat field by field, in order. A short directed
// table covers corners, edges, off-grid wrap and register extremes. A random
// part follows, with long low-value runs that push weights into saturation.
// ----------------------------------------------------------------------------
module momentum_random_walk_step_test;

   localparam int RANDOM_ITEMS = 650;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int WEIGHT_TOP   = 255;

   typedef struct packed {
      logic [mrw_pkg::OUT_BITS-1:0] col;
      logic [mrw_pkg::OUT_BITS-1:0] row;
      logic [mrw_pkg::DIR_BITS-1:0] heading;
   } walk_result_type;

   typedef struct {
      bit                           is_cfg;
      logic [mrw_pkg::CFG_BITS-1:0] cols, rows, scol, srow;
      logic                         kind;
      logic [mrw_pkg::RND_BITS-1:0] rnd;
      bit                           typed;
      walk_result_type              result;
   } stim_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_wr_en = 1'b0;
   logic [1:0]                   csr_index = mrw_pkg::CSR_GRID_COLS;
   logic [mrw_pkg::CFG_BITS-1:0] csr_wdata = '0;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_kind = mrw_pkg::KIND_RESTART;
   logic [mrw_pkg::RND_BITS-1:0] req_random_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [mrw_pkg::OUT_BITS-1:0] rsp_pos_col;
   logic [mrw_pkg::OUT_BITS-1:0] rsp_pos_row;
   logic [mrw_pkg::DIR_BITS-1:0] rsp_heading;

   // walker model state and its copy of the registers
   logic [15:0] walk_col, walk_row;
   logic [7:0]  walk_weight [mrw_pkg::DIR_COUNT];
   logic [15:0] grid_cols_q, grid_rows_q, start_col_q, start_row_q;

   walk_result_type expected_steps [$];
   stim_row_type    directed_rows [$];
   int              mismatches = 0;
   int              cycle_count = 0;
   int              stall_left = 0;
   bit              calm = 1'b0;

   momentum_random_walk_step i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_random_value (req_random_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pos_col      (rsp_pos_col),
      .rsp_pos_row      (rsp_pos_row),
      .rsp_heading      (rsp_heading)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // saturating weight updates
   function automatic void raise_weight(input logic [2:0] idx, input int amount);
      int w;
      w = walk_weight[idx] + amount;
      walk_weight[idx] = (w > WEIGHT_TOP) ? 8'(WEIGHT_TOP) : 8'(w);
   endfunction

   function automatic void lower_weight(input logic [2:0] idx, input int amount);
      int w;
      w = walk_weight[idx];
      walk_weight[idx] = (w > amount) ? 8'(w - amount) : 8'd0;
   endfunction

   // one walker step: restart or move, returns the position and heading
   function automatic walk_result_type next_position(input logic kind,
                                                     input logic [mrw_pkg::RND_BITS-1:0] rnd);
      walk_result_type res;
      logic [31:0]     total;
      logic [31:0]     prefix [mrw_pkg::DIR_COUNT];
      logic [31:0]     rem;
      logic [2:0]      dir;
      bit              found;
      dir = mrw_pkg::DIR_UP_LEFT;
      if (kind == mrw_pkg::KIND_RESTART) begin
         walk_col = start_col_q;
         walk_row = start_row_q;
         for (int i = 0; i < mrw_pkg::DIR_COUNT; i++)
            walk_weight[i] = 8'(mrw_pkg::WEIGHT_INIT);
      end else begin
         for (int i = 0; i < mrw_pkg::DIR_COUNT; i++)
            if (walk_weight[i] == '0) walk_weight[i] = 8'd1;
         // left edge wins over right, top over bottom
         if (walk_col == '0) begin
            walk_weight[mrw_pkg::DIR_UP_LEFT] = 8'd0;
            walk_weight[mrw_pkg::DIR_DOWN_LEFT] = 8'd0;
            walk_weight[mrw_pkg::DIR_LEFT] = 8'd0;
         end else if (walk_col == grid_cols_q) begin
            walk_weight[mrw_pkg::DIR_UP_RIGHT] = 8'd0;
            walk_weight[mrw_pkg::DIR_RIGHT] = 8'd0;
            walk_weight[mrw_pkg::DIR_DOWN_RIGHT] = 8'd0;
         end
         if (walk_row == '0) begin
            walk_weight[mrw_pkg::DIR_UP_LEFT] = 8'd0;
            walk_weight[mrw_pkg::DIR_UP] = 8'd0;
            walk_weight[mrw_pkg::DIR_UP_RIGHT] = 8'd0;
         end else if (walk_row == grid_rows_q) begin
            walk_weight[mrw_pkg::DIR_DOWN_RIGHT] = 8'd0;
            walk_weight[mrw_pkg::DIR_DOWN] = 8'd0;
            walk_weight[mrw_pkg::DIR_DOWN_LEFT] = 8'd0;
         end
         total = 32'd0;
         for (int i = 0; i < mrw_pkg::DIR_COUNT; i++) begin
            total = total + 32'(walk_weight[i]);
            prefix[i] = total;
         end
         rem = {1'b0, rnd} % total;
         dir = mrw_pkg::DIR_LEFT;
         found = 1'b0;
         for (int i = 0; i < mrw_pkg::DIR_COUNT; i++)
            if (!found && rem < prefix[i]) begin
               dir = 3'(i);
               found = 1'b1;
            end
         // one cell, diagonals included, coordinates wrap
         if (dir <= mrw_pkg::DIR_UP_RIGHT)
            walk_row = walk_row - 16'd1;
         if (dir >= mrw_pkg::DIR_UP_RIGHT && dir <= mrw_pkg::DIR_DOWN_RIGHT)
            walk_col = walk_col + 16'd1;
         if (dir >= mrw_pkg::DIR_DOWN_RIGHT && dir <= mrw_pkg::DIR_DOWN_LEFT)
            walk_row = walk_row + 16'd1;
         if (dir >= mrw_pkg::DIR_DOWN_LEFT || dir == mrw_pkg::DIR_UP_LEFT)
            walk_col = walk_col - 16'd1;
         // momentum: reinforce ahead, weaken behind
         raise_weight(dir + mrw_pkg::OFF_AHEAD, mrw_pkg::STEP_MAIN);
         raise_weight(dir + mrw_pkg::OFF_CW, mrw_pkg::STEP_SIDE);
         raise_weight(dir + mrw_pkg::OFF_CCW, mrw_pkg::STEP_SIDE);
         lower_weight(dir + mrw_pkg::OFF_BACK, mrw_pkg::STEP_MAIN);
         lower_weight(dir + mrw_pkg::OFF_BACK_L, mrw_pkg::STEP_SIDE);
         lower_weight(dir + mrw_pkg::OFF_BACK_R, mrw_pkg::STEP_SIDE);
      end
      res.col = walk_col;
      res.row = walk_row;
      res.heading = dir;
      return res;
   endfunction

   // mostly short gaps, a few long ones, none while calm
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 9);
      if (calm || pick < 5) return 0;
      if (pick < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [15:0] pick_extent();
      case ($urandom_range(0, 4))
         0: return 16'd1;
         1: return 16'($urandom_range(1, 4));
         2: return 16'($urandom_range(5, 300));
         3: return 16'hFFFF;
         default: return 16'($urandom_range(1, 65535));
      endcase
   endfunction

   function automatic logic [15:0] pick_start(input logic [15:0] extent);
      case ($urandom_range(0, 6))
         0: return 16'd0;
         1: return extent;
         2: return extent - 16'd1;
         3: return 16'($urandom_range(0, extent));
         4: return 16'hFFFF;
         5: return 16'($urandom_range(0, 65535));
         default: return extent >> 1;
      endcase
   endfunction

   function automatic stim_row_type cfg_row(input logic [15:0] cols, rows, scol, srow);
      stim_row_type r;
      r = '{default: '0};
      r.is_cfg = 1'b1;
      r.cols = cols;
      r.rows = rows;
      r.scol = scol;
      r.srow = srow;
      return r;
   endfunction

   function automatic stim_row_type item_row(input logic kind, input logic [30:0] rnd);
      stim_row_type r;
      r = '{default: '0};
      r.kind = kind;
      r.rnd = rnd;
      return r;
   endfunction

   function automatic stim_row_type typed_row(input logic kind, input logic [30:0] rnd,
                                              input logic [15:0] col, row,
                                              input logic [2:0] heading);
      stim_row_type r;
      r = item_row(kind, rnd);
      r.typed = 1'b1;
      r.result = '{col: col, row: row, heading: heading};
      return r;
   endfunction

   // writes all four registers on consecutive edges, block must be idle
   task automatic set_registers(input logic [15:0] cols, rows, scol, srow);
      csr_wr_en <= 1'b1;
      csr_index <= mrw_pkg::CSR_GRID_COLS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= mrw_pkg::CSR_GRID_ROWS;
      csr_wdata <= rows;
      @(posedge clock);
      csr_index <= mrw_pkg::CSR_START_COL;
      csr_wdata <= scol;
      @(posedge clock);
      csr_index <= mrw_pkg::CSR_START_ROW;
      csr_wdata <= srow;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      grid_cols_q = cols;
      grid_rows_q = rows;
      start_col_q = scol;
      start_row_q = srow;
   endtask

   // valid stays high across back-to-back beats; lowered only before a gap
   task automatic send_item(input logic kind, input logic [mrw_pkg::RND_BITS-1:0] rnd,
                            input bit typed, input walk_result_type typed_res);
      walk_result_type predicted;
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_random_value <= rnd;
      do @(posedge clock); while (req_stall);
      predicted = next_position(kind, rnd);
      expected_steps.push_back(typed ? typed_res : predicted);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_steps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [15:0] want, got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // response stall: random runs of open and stalled cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (calm || $urandom_range(0, 1) == 0) begin
         rsp_stall <= 1'b0;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_stall <= 1'b1;
         stall_left <= idle_length();
      end
   end

   // response checker
   always @(posedge clock) begin : response_check
      walk_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_steps.size() == 0) begin
            $display("%0t: unexpected response beat, col %0d row %0d heading %0d",
                     $time, rsp_pos_col, rsp_pos_row, rsp_heading);
            mismatches++;
         end else begin
            want = expected_steps.pop_front();
            check_field("pos_col", want.col, rsp_pos_col);
            check_field("pos_row", want.row, rsp_pos_row);
            check_field("heading", 16'(want.heading), 16'(rsp_heading));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int              random_sent;
      int              run;
      bit              momentum;
      logic [15:0]     cols, rows;
      logic            kind;
      logic [30:0]     rnd;
      walk_result_type none;

      none = '0;
      random_sent = 0;
      grid_cols_q = 16'd255;
      grid_rows_q = 16'd255;
      start_col_q = 16'd0;
      start_row_q = 16'd0;
      walk_col = 16'd0;
      walk_row = 16'd0;
      for (int i = 0; i < mrw_pkg::DIR_COUNT; i++)
         walk_weight[i] = 8'(mrw_pkg::WEIGHT_INIT);

      // reset registers: top-left corner, only right/down-right/down open
      directed_rows.push_back(typed_row(mrw_pkg::KIND_RESTART, 31'd0, 16'd0, 16'd0,
                                        mrw_pkg::DIR_UP_LEFT));
      directed_rows.push_back(typed_row(mrw_pkg::KIND_MOVE, 31'd0, 16'd1, 16'd0,
                                        mrw_pkg::DIR_RIGHT));
      directed_rows.push_back(item_row(mrw_pkg::KIND_MOVE, 31'h7FFFFFFF));
      directed_rows.push_back(item_row(mrw_pkg::KIND_MOVE, 31'd12345));
      // smallest grid, bottom-right corner
      directed_rows.push_back(cfg_row(16'd1, 16'd1, 16'd1, 16'd1));
      directed_rows.push_back(typed_row(mrw_pkg::KIND_RESTART, 31'h7FFFFFFF, 16'd1, 16'd1,
                                        mrw_pkg::DIR_UP_LEFT));
      directed_rows.push_back(typed_row(mrw_pkg::KIND_MOVE, 31'd0, 16'd0, 16'd0,
                                        mrw_pkg::DIR_UP_LEFT));
      directed_rows.push_back(item_row(mrw_pkg::KIND_MOVE, 31'h7FFFFFFF));
      directed_rows.push_back(item_row(mrw_pkg::KIND_MOVE, 31'd3));
      directed_rows.push_back(item_row(mrw_pkg::KIND_MOVE, 31'd5));
      // largest grid, start at its far corner
      directed_rows.push_back(cfg_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      directed_rows.push_back(typed_row(mrw_pkg::KIND_RESTART, 31'd0, 16'hFFFF, 16'hFFFF,
                                        mrw_pkg::DIR_UP_LEFT));
      directed_rows.push_back(typed_row(mrw_pkg::KIND_MOVE, 31'd5, 16'hFFFF, 16'hFFFE,
                                        mrw_pkg::DIR_UP));
      directed_rows.push_back(item_row(mrw_pkg::KIND_MOVE, 31'h2AAAAAAA));
      directed_rows.push_back(item_row(mrw_pkg::KIND_MOVE, 31'h55555555));
      // off-grid start: no masking, column wraps past the top of its range
      directed_rows.push_back(cfg_row(16'd1, 16'd1, 16'hFFFF, 16'd100));
      directed_rows.push_back(typed_row(mrw_pkg::KIND_RESTART, 31'd0, 16'hFFFF, 16'd100,
                                        mrw_pkg::DIR_UP_LEFT));
      directed_rows.push_back(typed_row(mrw_pkg::KIND_MOVE, 31'd9, 16'd0, 16'd100,
                                        mrw_pkg::DIR_RIGHT));
      directed_rows.push_back(item_row(mrw_pkg::KIND_MOVE, 31'd0));
      directed_rows.push_back(item_row(mrw_pkg::KIND_MOVE, 31'h7FFFFFFF));
      // left edge together with bottom edge
      directed_rows.push_back(cfg_row(16'd3, 16'd2, 16'd0, 16'd2));
      directed_rows.push_back(typed_row(mrw_pkg::KIND_RESTART, 31'd77, 16'd0, 16'd2,
                                        mrw_pkg::DIR_UP_LEFT));
      directed_rows.push_back(typed_row(mrw_pkg::KIND_MOVE, 31'd0, 16'd0, 16'd1,
                                        mrw_pkg::DIR_UP));
      directed_rows.push_back(item_row(mrw_pkg::KIND_MOVE, 31'd1234567));
      directed_rows.push_back(item_row(mrw_pkg::KIND_MOVE, 31'd7654321));
      directed_rows.push_back(item_row(mrw_pkg::KIND_MOVE, 31'd0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         if (directed_rows[n].is_cfg) begin
            wait_idle();
            set_registers(directed_rows[n].cols, directed_rows[n].rows,
                          directed_rows[n].scol, directed_rows[n].srow);
         end else begin
            send_item(directed_rows[n].kind, directed_rows[n].rnd,
                      directed_rows[n].typed, directed_rows[n].result);
         end
      end

      // random walks; momentum runs keep picking up-left to saturate weights
      while (random_sent < RANDOM_ITEMS) begin
         momentum = ($urandom_range(0, 7) == 0);
         calm = ($urandom_range(0, 4) == 0);
         if (momentum || $urandom_range(0, 2) == 0) begin
            wait_idle();
            if (momentum) begin
               set_registers(16'hFFFF, 16'hFFFF, 16'($urandom_range(200, 65000)),
                             16'($urandom_range(200, 65000)));
            end else begin
               cols = pick_extent();
               rows = pick_extent();
               set_registers(cols, rows, pick_start(cols), pick_start(rows));
            end
         end
         run = momentum ? $urandom_range(90, 130) : $urandom_range(1, 30);
         if (momentum || $urandom_range(0, 3) != 0) begin
            send_item(mrw_pkg::KIND_RESTART, 31'($urandom), 1'b0, none);
            random_sent++;
         end
         for (int j = 0; j < run; j++) begin
            kind = ($urandom_range(0, 11) == 0) ? mrw_pkg::KIND_RESTART
                                                 : mrw_pkg::KIND_MOVE;
            if (momentum) begin
               kind = mrw_pkg::KIND_MOVE;
               rnd = 31'($urandom_range(0, 2));
            end else if ($urandom_range(0, 3) == 0) begin
               rnd = 31'($urandom_range(0, 40));
            end else begin
               rnd = 31'($urandom);
            end
            send_item(kind, rnd, 1'b0, none);
            random_sent++;
         end
      end

      calm = 1'b0;
      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_steps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
